// File: sv/tme_pkg.sv
// ----------------------------------------------------------------------------
// tme_pkg: shared types for the tape machine execute unit
// Opcode encoding and the instruction record that moves down the pipeline.
// ----------------------------------------------------------------------------
package tme_pkg;

  typedef enum logic [2:0] {
    OP_INC   = 3'd0,
    OP_DEC   = 3'd1,
    OP_LEFT  = 3'd2,
    OP_RIGHT = 3'd3,
    OP_OUT   = 3'd4,
    OP_IN    = 3'd5,
    OP_OPEN  = 3'd6,
    OP_CLOSE = 3'd7
  } op_t;

  // Only the low byte of the repeat amount matters for cell arithmetic;
  // the full amount goes through the step reduction unit instead.
  typedef struct packed {
    op_t         mode;
    logic [7:0]  amount_lo;
    logic [15:0] cur_pc;
    logic [15:0] jump_target;
    logic [7:0]  in_byte;
  } instr_t;

endpackage

// File: sv/tape_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// tape_machine_execute_unit: execute stage of an eight-opcode tape machine
// Executes folded instructions against a byte tape and a cell pointer and
// returns one result per instruction.
// ----------------------------------------------------------------------------
// The unit sustains one instruction per clock unless out_tready stalls it: a
// new transfer is taken every cycle and each produces exactly one result
// transfer, after move distance reduction, tape read and the output register.
// The tape lives in a single dual-port RAM; a cell read-modify-write is
// finished as the instruction leaves the read stage, and a one-entry
// forwarding register covers the instruction that follows directly on the
// same cell, so back-to-back increments, loops and outputs need no interlock.
// The pointer is updated by an add or a subtract with wrap correction as an
// instruction enters the read stage. After reset the unit clears the tape,
// one cell per cycle, and holds in_tready low until every cell is cleared.
module tape_machine_execute_unit #(
  parameter int unsigned TAPE_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata, from bit 0: amount[15:0], cur_pc[15:0], jump_target[15:0],
  // in_byte[7:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  // in_tuser: mode[2:0]
  input  logic [2:0]  in_tuser,
  // out_tdata, from bit 0: out_byte[7:0], next_pc[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // out_tuser: out_valid
  output logic        out_tuser
);
  import tme_pkg::*;

  localparam int unsigned PW = $clog2(TAPE_DEPTH);
  localparam logic [PW-1:0] LAST_CELL = PW'(TAPE_DEPTH - 1);

  // Tape clearing after reset.
  logic          clr_busy_r;
  logic [PW-1:0] clr_addr_r;

  // Pipeline stage valids and payloads.
  logic          v1_r, v2_r, v3_r;
  instr_t        s1_r, s2_r, s3_r;
  logic [PW-1:0] addr3_r;
  logic          en1, en2, en3, en_o;
  logic          in_xfer;

  // Forwarding of the write that the read of the next instruction missed.
  logic          fwd_v_r;
  logic [PW-1:0] fwd_addr_r;
  logic [7:0]    fwd_data_r;

  logic [PW-1:0] step;
  logic [PW-1:0] ptr;
  logic [7:0]    rd_data;
  logic [7:0]    cur_cell;
  logic [7:0]    cell_nxt;
  logic          cell_wr;
  logic          taken;
  logic [15:0]   next_pc;
  logic [7:0]    out_byte;
  logic          out_flag;

  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;

  logic          out_tvalid_r;
  logic [23:0]   out_tdata_r;
  logic          out_tuser_r;

  assign en_o      = !out_tvalid_r || out_tready;
  assign en3       = !v3_r || en_o;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = !clr_busy_r && en1;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == LAST_CELL) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + PW'(1);
      end
    end
  end

  tme_step #(
    .DEPTH(TAPE_DEPTH)
  ) u_step (
    .clk   (clk),
    .load_a(in_xfer),
    .load_b(en2),
    .amount(in_tdata[15:0]),
    .step  (step)
  );

  tme_ptr #(
    .DEPTH(TAPE_DEPTH)
  ) u_ptr (
    .clk  (clk),
    .rst_n(rst_n),
    .upd  (en3 && v2_r),
    .mode (s2_r.mode),
    .step (step),
    .ptr  (ptr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_xfer;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_r.mode        <= op_t'(in_tuser);
      s1_r.amount_lo   <= in_tdata[7:0];
      s1_r.cur_pc      <= in_tdata[31:16];
      s1_r.jump_target <= in_tdata[47:32];
      s1_r.in_byte     <= in_tdata[55:48];
    end
    if (en2) begin
      s2_r <= s1_r;
    end
    if (en3) begin
      s3_r    <= s2_r;
      addr3_r <= ptr;
    end
  end

  // The read issued as an instruction enters the last stage cannot see the
  // write made at that same edge, so that write is kept for one compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (en3) begin
      fwd_v_r <= v3_r && cell_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      fwd_addr_r <= addr3_r;
      fwd_data_r <= cell_nxt;
    end
  end

  assign cur_cell = (fwd_v_r && (fwd_addr_r == addr3_r)) ? fwd_data_r : rd_data;

  always_comb begin
    cell_nxt = cur_cell;
    cell_wr  = 1'b0;
    taken    = 1'b0;
    out_byte = 8'd0;
    out_flag = 1'b0;
    case (s3_r.mode)
      OP_INC: begin
        cell_nxt = cur_cell + s3_r.amount_lo;
        cell_wr  = 1'b1;
      end
      OP_DEC: begin
        cell_nxt = cur_cell - s3_r.amount_lo;
        cell_wr  = 1'b1;
      end
      OP_IN: begin
        cell_nxt = s3_r.in_byte;
        cell_wr  = 1'b1;
      end
      OP_OUT: begin
        out_byte = cur_cell;
        out_flag = 1'b1;
      end
      OP_OPEN:  taken = (cur_cell == 8'd0);
      OP_CLOSE: taken = (cur_cell != 8'd0);
      default: begin
        cell_wr = 1'b0;
      end
    endcase
    next_pc = taken ? (s3_r.jump_target + 16'd1) : (s3_r.cur_pc + 16'd1);
  end

  always_comb begin
    if (clr_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 8'd0;
    end else begin
      ram_we    = v3_r && en3 && cell_wr;
      ram_waddr = addr3_r;
      ram_wdata = cell_nxt;
    end
  end

  tme_ram #(
    .WIDTH(8),
    .DEPTH(TAPE_DEPTH)
  ) u_tape (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (en3),
    .rd_addr(ptr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en_o) begin
      out_tvalid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_o && v3_r) begin
      out_tdata_r <= {next_pc, out_byte};
      out_tuser_r <= out_flag;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// File: sv/tme_ram.sv
// ----------------------------------------------------------------------------
// tme_ram: generic simple dual-port RAM
// One write port and one read port with a registered read. A read of an
// address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module tme_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/tme_step.sv
// ----------------------------------------------------------------------------
// tme_step: move distance reduction
// Reduces the 16-bit repeat amount modulo the tape depth over two register
// stages. A non power of two depth uses a reciprocal multiply and a
// back multiply; the reciprocal is rounded up, which makes the quotient exact
// for every 16-bit amount.
// ----------------------------------------------------------------------------
module tme_step #(
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     load_a,
  input  logic                     load_b,
  input  logic [15:0]              amount,
  output logic [$clog2(DEPTH)-1:0] step
);

  localparam int unsigned PW = $clog2(DEPTH);

  generate
    if (DEPTH > 65536) begin : g_wide
      logic [15:0]   amt_r;
      logic [PW-1:0] step_r;

      always_ff @(posedge clk) begin
        if (load_a) begin
          amt_r <= amount;
        end
        if (load_b) begin
          step_r <= PW'(amt_r);
        end
      end

      assign step = step_r;
    end else if ((DEPTH & (DEPTH - 1)) == 0) begin : g_pow2
      logic [15:0]   amt_r;
      logic [PW-1:0] step_r;

      always_ff @(posedge clk) begin
        if (load_a) begin
          amt_r <= amount;
        end
        if (load_b) begin
          step_r <= amt_r[PW-1:0];
        end
      end

      assign step = step_r;
    end else begin : g_recip
      localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(DEPTH) - 64'd1) / 64'(DEPTH));

      logic [15:0]   amt_r;
      logic [15:0]   quot_r;
      logic [48:0]   prod_nxt;
      logic [31:0]   back_prod;
      logic [31:0]   rem;
      logic [PW-1:0] step_r;

      always_comb begin
        prod_nxt  = 49'(amount) * 49'(RECIP);
        back_prod = 32'(quot_r) * 32'(DEPTH);
        rem       = 32'(amt_r) - back_prod;
      end

      always_ff @(posedge clk) begin
        if (load_a) begin
          amt_r  <= amount;
          quot_r <= prod_nxt[47:32];
        end
        if (load_b) begin
          step_r <= rem[PW-1:0];
        end
      end

      assign step = step_r;
    end
  endgenerate

endmodule

// File: sv/tme_ptr.sv
// ----------------------------------------------------------------------------
// tme_ptr: cell pointer register
// Holds the tape pointer and moves it left or right by a reduced step,
// wrapping at the tape depth by an add and compare, or a subtract and borrow.
// ----------------------------------------------------------------------------
module tme_ptr #(
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     upd,
  input  tme_pkg::op_t             mode,
  input  logic [$clog2(DEPTH)-1:0] step,
  output logic [$clog2(DEPTH)-1:0] ptr
);
  import tme_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam logic [PW:0] DEP = (PW + 1)'(DEPTH);

  logic [PW-1:0] ptr_r;
  logic [PW-1:0] ptr_nxt;
  logic [PW:0]   sum;
  logic [PW:0]   diff;
  logic [PW:0]   right_pos;
  logic [PW:0]   left_pos;

  always_comb begin
    sum       = {1'b0, ptr_r} + {1'b0, step};
    diff      = {1'b0, ptr_r} - {1'b0, step};
    right_pos = (sum >= DEP) ? (sum - DEP) : sum;
    // A borrow out of the subtraction means the move crossed cell zero.
    left_pos  = diff[PW] ? (diff + DEP) : diff;
    case (mode)
      OP_LEFT:  ptr_nxt = left_pos[PW-1:0];
      OP_RIGHT: ptr_nxt = right_pos[PW-1:0];
      default:  ptr_nxt = ptr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (upd) begin
      ptr_r <= ptr_nxt;
    end
  end

  assign ptr = ptr_r;

endmodule

// File: bench/tme_execute_checker.sv
// ----------------------------------------------------------------------------
// tme_execute_checker: result checker for the tape machine execute unit
// Watches both stream channels, keeps its own tape and cell pointer, works
// out the result of every accepted instruction and compares each result
// transfer, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tme_execute_checker #(
  parameter int unsigned TAPE_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tuser,
  output int          fail_count,
  output int          pending,
  output int          results_checked
);
  import tme_pkg::*;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [15:0] next_pc;
  } exec_result_t;

  logic [7:0]   tape_model [TAPE_DEPTH];
  int unsigned  cell_ptr;
  exec_result_t expected_results [$];

  initial begin
    fail_count      = 0;
    pending         = 0;
    results_checked = 0;
  end

  // Executes one instruction against the local tape and returns its result.
  function automatic exec_result_t execute_instr(op_t op, logic [15:0] amount,
                                                 logic [15:0] cur_pc,
                                                 logic [15:0] jump_target,
                                                 logic [7:0] in_byte);
    exec_result_t r;
    logic [7:0]   cur_cell;
    int unsigned  step;
    cur_cell    = tape_model[cell_ptr];
    step        = amount % TAPE_DEPTH;
    r.out_byte  = 8'd0;
    r.out_valid = 1'b0;
    r.next_pc   = cur_pc + 16'd1;
    case (op)
      OP_INC:   tape_model[cell_ptr] = cur_cell + amount[7:0];
      OP_DEC:   tape_model[cell_ptr] = cur_cell - amount[7:0];
      OP_LEFT:  cell_ptr = (cell_ptr + TAPE_DEPTH - step) % TAPE_DEPTH;
      OP_RIGHT: cell_ptr = (cell_ptr + step) % TAPE_DEPTH;
      OP_OUT: begin
        r.out_byte  = cur_cell;
        r.out_valid = 1'b1;
      end
      OP_IN:    tape_model[cell_ptr] = in_byte;
      OP_OPEN:  if (cur_cell == 8'd0) r.next_pc = jump_target + 16'd1;
      OP_CLOSE: if (cur_cell != 8'd0) r.next_pc = jump_target + 16'd1;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned expv, int unsigned got);
    fail_count++;
    $display("MISMATCH at result %0d, %s: expected 0x%0h, got 0x%0h",
             results_checked, what, expv, got);
  endtask

  always @(posedge clk) begin
    exec_result_t want;
    exec_result_t predicted;
    if (!rst_n) begin
      foreach (tape_model[i]) tape_model[i] = 8'd0;
      cell_ptr = 0;
      expected_results.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predicted = execute_instr(op_t'(in_tuser), in_tdata[15:0],
                                  in_tdata[31:16], in_tdata[47:32],
                                  in_tdata[55:48]);
        expected_results = {expected_results, predicted};
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", 0, 32'(out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", 32'(want.out_byte), 32'(out_tdata[7:0]));
          if (out_tuser !== want.out_valid)
            report_mismatch("out_valid", 32'(want.out_valid), 32'(out_tuser));
          if (out_tdata[23:8] !== want.next_pc)
            report_mismatch("next_pc", 32'(want.next_pc), 32'(out_tdata[23:8]));
        end
        results_checked++;
      end
    end
    pending <= expected_results.size();
  end

endmodule

// File: bench/tb_tape_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// tb_tape_machine_execute_unit: testbench for the tape machine execute unit
// Drives a short directed list of edge cases, then random instruction runs
// that mostly work on one cell at a time, with bursty input and a changing
// output stall pattern. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_tape_machine_execute_unit;
  import tme_pkg::*;

  localparam int unsigned TAPE_DEPTH   = 32768;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          DRAIN_CYCLES = 16;
  // The limit also covers the tape clear after reset.
  localparam int          CYCLE_LIMIT  = 600000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tuser;

  int fail_count;
  int pending;
  int results_checked;
  int cycles       = 0;
  int sent_total   = 0;
  int burst_left   = 1;
  bit valid_up     = 1'b0;

  op_t cell_ops [6] = '{OP_INC, OP_DEC, OP_OUT, OP_IN, OP_OPEN, OP_CLOSE};

  tape_machine_execute_unit #(.TAPE_DEPTH(TAPE_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tme_execute_checker #(.TAPE_DEPTH(TAPE_DEPTH)) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: a stall style is picked for a random span of cycles.
  initial begin : ready_pattern
    int style;
    int span;
    forever begin
      style = $urandom_range(0, 4);
      span  = $urandom_range(32, 256);
      for (int i = 0; i < span; i++) begin
        @(posedge clk);
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          3:       out_tready <= ((i % 8) < 5);
          default: out_tready <= (i >= 30);
        endcase
      end
    end
  end

  // Presents one instruction and waits for its transfer. Bursts end with a
  // random gap; some bursts are long and run without any gap.
  task automatic send_instr(op_t op, logic [15:0] amount, logic [15:0] pc,
                            logic [15:0] jt, logic [7:0] byte_in);
    int gap;
    in_tvalid <= 1'b1;
    valid_up = 1'b1;
    in_tdata  <= {byte_in, jt, pc, amount};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    sent_total++;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(40, 150);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
      end
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        valid_up = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [15:0] cell_amount();
    case ($urandom_range(0, 3))
      0, 1:    return 16'($urandom_range(0, 3));
      2:       return {8'($urandom), 8'($urandom_range(254, 255))};
      default: return 16'($urandom);
    endcase
  endfunction

  // Half are short moves so that cells get revisited; the rest are near the tape
  // depth or the top of the 16-bit range to wrap the pointer, or random.
  function automatic logic [15:0] move_amount();
    case ($urandom_range(0, 5))
      0, 1, 2: return 16'($urandom_range(0, 3));
      3:       return 16'($urandom_range(TAPE_DEPTH - 2, TAPE_DEPTH + 2));
      4:       return 16'($urandom_range(65533, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] input_byte();
    return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
  endfunction

  initial begin : stimulus
    int directed_count;
    int sel;
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed edge cases on the cell value, the pointer and the pc wrap.
    send_instr(OP_OUT,   16'hFFFF, 16'h0000, 16'hFFFF, 8'hFF);
    send_instr(OP_OPEN,  16'h1234, 16'h0010, 16'hFFFF, 8'h00);
    send_instr(OP_CLOSE, 16'h0000, 16'hFFFF, 16'h0000, 8'hFF);
    send_instr(OP_INC,   16'hFFFF, 16'h0001, 16'h5555, 8'hAA);
    send_instr(OP_OUT,   16'h0000, 16'h0002, 16'h0000, 8'h00);
    send_instr(OP_CLOSE, 16'h0000, 16'h0003, 16'h04D2, 8'h00);
    send_instr(OP_OPEN,  16'h0000, 16'hFFFF, 16'hAAAA, 8'h00);
    send_instr(OP_INC,   16'h0001, 16'h0004, 16'h0000, 8'h00);
    send_instr(OP_DEC,   16'h0001, 16'h0005, 16'h0000, 8'h00);
    send_instr(OP_DEC,   16'h0100, 16'h0006, 16'h0000, 8'h00);
    send_instr(OP_OUT,   16'h0000, 16'h0007, 16'h0000, 8'h00);
    send_instr(OP_IN,    16'hFFFF, 16'h0008, 16'h0000, 8'hFF);
    send_instr(OP_OUT,   16'h0000, 16'h0009, 16'h0000, 8'h00);
    send_instr(OP_LEFT,  16'h0001, 16'h000A, 16'h0000, 8'h00);
    send_instr(OP_INC,   16'h0007, 16'h000B, 16'h0000, 8'h00);
    send_instr(OP_RIGHT, 16'h0001, 16'h000C, 16'h0000, 8'h00);
    send_instr(OP_OUT,   16'h0000, 16'h000D, 16'h0000, 8'h00);
    send_instr(OP_RIGHT, 16'h8000, 16'h000E, 16'h0000, 8'h00);
    send_instr(OP_RIGHT, 16'hFFFF, 16'h000F, 16'h0000, 8'h00);
    send_instr(OP_OUT,   16'h0000, 16'h0010, 16'h0000, 8'h00);
    send_instr(OP_LEFT,  16'h0000, 16'h0011, 16'h0000, 8'h00);
    send_instr(OP_LEFT,  16'hFFFF, 16'h0012, 16'h0000, 8'h00);
    send_instr(OP_RIGHT, 16'h7FFF, 16'h0013, 16'h0000, 8'h00);
    send_instr(OP_IN,    16'h0000, 16'h0014, 16'h0000, 8'hA5);
    send_instr(OP_OUT,   16'h0000, 16'h0015, 16'h0000, 8'h00);
    directed_count = sent_total;

    // Random part: runs of cell operations, moves, and plain noise.
    while (sent_total - directed_count < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        len = $urandom_range(2, 8);
        for (int i = 0; i < len; i++)
          send_instr(cell_ops[$urandom_range(0, 5)], cell_amount(), 16'($urandom),
                     16'($urandom), input_byte());
      end else if (sel < 85) begin
        send_instr(op_t'($urandom_range(0, 1) ? OP_LEFT : OP_RIGHT), move_amount(),
                   16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        send_instr(op_t'($urandom_range(0, 7)), 16'($urandom), 16'($urandom),
                   16'($urandom), 8'($urandom));
      end
    end

    if (valid_up) begin
      in_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Drove %0d instructions (%0d directed, %0d random) over all eight opcodes",
             sent_total, directed_count, sent_total - directed_count);
    $display("Checked %0d results under bursty input and changing output stalls",
             results_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
